@@ src/pcs_pkg.sv @@
// Package for the channel smoother: sizes, field widths and the per-step result record.
// No dependencies; imported by pcs_chan_state and pot_channel_smoother.
`default_nettype none

package pcs_pkg;

  localparam int CHANNELS    = 13;
  localparam int SAMPLE_BITS = 10;
  localparam int CHAN_W      = 4;
  localparam int LEVEL_W     = 7;
  localparam int ACC_W       = LEVEL_W + 2;
  localparam int CNT_W       = 2;
  localparam int IN_DATA_W   = ((CHAN_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((CHAN_W + LEVEL_W + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = {LEVEL_W{1'b1}};
  localparam logic [CNT_W-1:0]   LAST_CNT   = {CNT_W{1'b1}};

  typedef struct packed {
    logic               hit;
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               changed;
  } pcs_result_t;

endpackage

`default_nettype wire

@@ src/pcs_chan_state.sv @@
// Per-channel accumulator, sample count and last level, plus the averaging update.
// Depends on pcs_pkg.
`default_nettype none

module pcs_chan_state import pcs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [CHAN_W-1:0]      chan,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   invert,
  output pcs_result_t                 res
);

  logic [ACC_W-1:0]   acc_r  [CHANNELS];
  logic [CNT_W-1:0]   cnt_r  [CHANNELS];
  logic [LEVEL_W-1:0] prev_r [CHANNELS];

  logic               in_range;
  logic               upd;
  logic [LEVEL_W-1:0] scaled;
  logic [ACC_W-1:0]   sum;
  logic [LEVEL_W-1:0] avg;
  logic [LEVEL_W:0]   mid;
  logic [LEVEL_W-1:0] lvl;
  logic [ACC_W-1:0]   acc_cur;
  logic [CNT_W-1:0]   cnt_cur;
  logic [LEVEL_W-1:0] prev_cur;

  assign in_range = ({1'b0, chan} < (CHAN_W + 1)'(CHANNELS));
  assign upd      = step && in_range;

  always_comb begin
    acc_cur  = '0;
    cnt_cur  = '0;
    prev_cur = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (chan == CHAN_W'(i)) begin
        acc_cur  = acc_r[i];
        cnt_cur  = cnt_r[i];
        prev_cur = prev_r[i];
      end
    end
  end

  always_comb begin
    scaled = sample[SAMPLE_BITS-1 -: LEVEL_W];
    if (invert) begin
      scaled = FULL_LEVEL - scaled;
    end
    sum = acc_cur + ACC_W'(scaled);
    avg = sum[ACC_W-1:2];
    mid = {1'b0, prev_cur} + {1'b0, avg};
    lvl = (avg == FULL_LEVEL) ? FULL_LEVEL : mid[LEVEL_W:1];
  end

  always_comb begin
    res.hit     = upd && (cnt_cur == LAST_CNT);
    res.chan    = chan;
    res.level   = lvl;
    res.changed = (lvl != prev_cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_r[i]  <= '0;
        cnt_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (chan == CHAN_W'(i)) begin
          if (cnt_cur == LAST_CNT) begin
            acc_r[i]  <= '0;
            cnt_r[i]  <= '0;
            prev_r[i] <= lvl;
          end else begin
            acc_r[i] <= sum;
            cnt_r[i] <= cnt_cur + CNT_W'(1);
          end
        end
      end
    end
  end

  a_hit_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> step && in_range)
    else $error("result without an in-range step");

  a_count_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |=> cnt_cur == '0 || $past(chan) != chan)
    else $error("count not cleared after result");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !res.hit |=> (chan != $past(chan)) || (cnt_cur == $past(cnt_cur) + CNT_W'(1)))
    else $error("count did not advance");

  a_level_stored: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |=> (chan != $past(chan)) || (prev_cur == $past(lvl)))
    else $error("level not stored");

endmodule

`default_nettype wire

@@ src/pot_channel_smoother.sv @@
// Top level of the channel smoother: input register, channel state update, result register.
// Depends on pcs_pkg and pcs_chan_state.
// An accepted input goes to the input register, then its result to the result register.
// One input per cycle unless out_tready stalls; one result per fourth sample of a channel.
// Reset (rst_n low, synchronous): clears invert, all channel state and both valid flags.
`default_nettype none

module pot_channel_smoother import pcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,   // invert
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,    // channel[3:0], sample[13:4], zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // channel_out[3:0], level[10:4], zero pad
  output logic                       out_tuser    // changed
);

  logic                   invert_r;
  logic                   in_v_r;
  logic [CHAN_W-1:0]      in_ch_r;
  logic [SAMPLE_BITS-1:0] in_smp_r;
  logic                   out_v_r;
  logic [CHAN_W-1:0]      out_ch_r;
  logic [LEVEL_W-1:0]     out_lvl_r;
  logic                   out_chg_r;
  logic                   adv;
  pcs_result_t            res;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      invert_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r  <= in_tdata[CHAN_W-1:0];
      in_smp_r <= in_tdata[CHAN_W +: SAMPLE_BITS];
    end
  end

  pcs_chan_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .chan   (in_ch_r),
    .sample (in_smp_r),
    .invert (invert_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res.hit;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.hit) begin
      out_ch_r  <= res.chan;
      out_lvl_r <= res.level;
      out_chg_r <= res.changed;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'({out_lvl_r, out_ch_r});
  assign out_tuser  = out_chg_r;

endmodule

`default_nettype wire
